FILE: design/bmad_pkg.sv
// Shared types and fixed field widths for the block mean / absolute deviation unit.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package bmad_pkg;

    // Widths of the fields on the ports.
    localparam int SAMPLE_W = 10;
    localparam int MEAN_W   = 10;
    localparam int DEV_W    = 15;

    // Top level sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } bmad_state_t;

endpackage

FILE: design/bmad_mem.sv
// Sample buffer: one write port and one read port with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module bmad_mem #(
    parameter int DEPTH_LOG2 = 5,
    parameter int WIDTH      = 10
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [DEPTH_LOG2-1:0] wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [DEPTH_LOG2-1:0] rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [2**DEPTH_LOG2];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bmad_scan.sv
// Deviation pass: walks every buffer entry and sums the absolute difference to the mean.
// Drives the read port of bmad_mem; no package dependencies.
`timescale 1ns / 1ps

module bmad_scan #(
    parameter int BLOCK_LOG2  = 5,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [SAMPLE_BITS-1:0]            mean,
    output logic                              rd_en,
    output logic [BLOCK_LOG2-1:0]             rd_addr,
    input  logic [SAMPLE_BITS-1:0]            rd_data,
    output logic                              done,
    output logic [SAMPLE_BITS+BLOCK_LOG2-1:0] dev_sum
);

    localparam int SUM_W = SAMPLE_BITS + BLOCK_LOG2;
    localparam logic [BLOCK_LOG2-1:0] LAST_ADDR = {BLOCK_LOG2{1'b1}};

    logic                    active_reg;
    logic [BLOCK_LOG2-1:0]   addr_reg;
    logic                    pend_reg;
    logic                    pend_last_reg;
    logic                    done_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SAMPLE_BITS-1:0]  abs_diff;

    // Absolute difference between the entry just read and the mean.
    assign abs_diff = (rd_data >= mean) ? (rd_data - mean) : (mean - rd_data);

    // Address counter and read pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            pend_reg      <= active_reg;
            pend_last_reg <= active_reg && (addr_reg == LAST_ADDR);
            done_reg      <= pend_reg && pend_last_reg;
            if (start)
            begin
                active_reg <= 1'b1;
                addr_reg   <= '0;
            end
            else if (active_reg)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    // Accumulator; cleared when a pass starts, updated as read data arrives.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= '0;
        end
        else if (pend_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(abs_diff);
        end
    end

    assign rd_en   = active_reg;
    assign rd_addr = addr_reg;
    assign done    = done_reg;
    assign dev_sum = sum_reg;

endmodule

FILE: design/block_mean_abs_deviation.sv
// Block mean and sum of absolute deviations over 2**BLOCK_LOG2 samples.
// Samples are stored in the buffer as they transfer; after the last sample of a block the input
// stalls for the deviation pass, one buffer read per entry, and until the result has been loaded
// into the output register, which waits while a pending result is stalled.
// rst_n (asynchronous, active low) clears position, total and control; buffer is not cleared.
`timescale 1ns / 1ps

module block_mean_abs_deviation #(
    parameter int BLOCK_LOG2  = 5,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bmad_pkg::SAMPLE_W-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bmad_pkg::MEAN_W-1:0]   block_mean,
    output logic [bmad_pkg::DEV_W-1:0]    abs_deviation_sum
);

    import bmad_pkg::*;

    localparam int TOT_W = SAMPLE_BITS + BLOCK_LOG2;
    localparam logic [BLOCK_LOG2-1:0] LAST_POS = {BLOCK_LOG2{1'b1}};

    bmad_state_t               state_reg;
    bmad_state_t               state_next;
    logic [BLOCK_LOG2-1:0]     wp_reg;
    logic [TOT_W-1:0]          total_reg;
    logic [TOT_W-1:0]          total_next;
    logic [SAMPLE_BITS-1:0]    mean_reg;
    logic [SAMPLE_BITS-1:0]    s_in;
    logic                      in_xfer;
    logic                      block_end;
    logic                      scan_start;
    logic                      load_out;
    logic                      rd_en;
    logic [BLOCK_LOG2-1:0]     rd_addr;
    logic [SAMPLE_BITS-1:0]    rd_data;
    logic                      scan_done;
    logic [TOT_W-1:0]          dev_sum;
    logic [MEAN_W-1:0]         mean_sat;
    logic [DEV_W-1:0]          dev_sat;
    logic                      out_valid_reg;
    logic [MEAN_W-1:0]         mean_out_reg;
    logic [DEV_W-1:0]          dev_out_reg;

    // Keep only the low SAMPLE_BITS bits of the input, or zero-extend it when SAMPLE_BITS is wider.
    generate
        if (SAMPLE_BITS <= SAMPLE_W)
        begin : g_in_narrow
            assign s_in = sample[SAMPLE_BITS-1:0];
        end
        else
        begin : g_in_wide
            assign s_in = SAMPLE_BITS'(sample);
        end
    endgenerate

    assign in_xfer    = in_valid && !in_stall;
    assign block_end  = in_xfer && (wp_reg == LAST_POS);
    assign total_next = total_reg + TOT_W'(s_in);

    // Sequencer: accept samples, run the deviation pass, hand off the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        scan_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // The input is open here, so a valid last sample is a transfer.
                in_stall = 1'b0;
                if (in_valid && (wp_reg == LAST_POS))
                begin
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Write position and running total.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            total_reg <= '0;
        end
        else if (in_xfer)
        begin
            wp_reg    <= wp_reg + 1'b1;
            total_reg <= block_end ? '0 : total_next;
        end
    end

    // Truncated mean of the block, captured with its last sample.
    always_ff @(posedge clk)
    begin
        if (block_end)
        begin
            mean_reg <= total_next[TOT_W-1:BLOCK_LOG2];
        end
    end

    // The buffer is only read while the input is stalled, so reads and writes never overlap.
    bmad_mem #(
        .DEPTH_LOG2 (BLOCK_LOG2),
        .WIDTH      (SAMPLE_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (in_xfer),
        .wr_addr (wp_reg),
        .wr_data (s_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bmad_scan #(
        .BLOCK_LOG2  (BLOCK_LOG2),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .mean    (mean_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (scan_done),
        .dev_sum (dev_sum)
    );

    // Clamp results to the output field widths.
    generate
        if (SAMPLE_BITS > MEAN_W)
        begin : g_mean_sat
            assign mean_sat = (|mean_reg[SAMPLE_BITS-1:MEAN_W]) ? '1 : mean_reg[MEAN_W-1:0];
        end
        else
        begin : g_mean_fit
            assign mean_sat = MEAN_W'(mean_reg);
        end
        if (TOT_W > DEV_W)
        begin : g_dev_sat
            assign dev_sat = (|dev_sum[TOT_W-1:DEV_W]) ? '1 : dev_sum[DEV_W-1:0];
        end
        else
        begin : g_dev_fit
            assign dev_sat = DEV_W'(dev_sum);
        end
    endgenerate

    // Output register; a pending result does not block new sample transfers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            mean_out_reg <= mean_sat;
            dev_out_reg  <= dev_sat;
        end
    end

    assign out_valid         = out_valid_reg;
    assign block_mean        = mean_out_reg;
    assign abs_deviation_sum = dev_out_reg;

endmodule

FILE: design/bmad_checker.sv
// Port-level checks for block_mean_abs_deviation, attached by the bind at the end.
// Depends on bmad_pkg for field widths.
`timescale 1ns / 1ps

module bmad_checker #(
    parameter int BLOCK_LOG2 = 5
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [bmad_pkg::MEAN_W-1:0] block_mean,
    input logic [bmad_pkg::DEV_W-1:0]  abs_deviation_sum
);

    import bmad_pkg::*;

    logic [BLOCK_LOG2-1:0] cnt_reg;

    // Count sample transfers within the current block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (in_valid && !in_stall)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(block_mean)
            && $stable(abs_deviation_sum))
        else $error("result changed while stalled");

    // The input only stalls once a whole block has been transferred.
    a_stall_at_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> (cnt_reg == '0))
        else $error("input stalled in the middle of a block");

    // A new result only appears at the end of a deviation pass.
    a_result_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a deviation pass");

    // When the pass ends and the input reopens, the result is waiting.
    a_reopen_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("input reopened without a result");

endmodule

bind block_mean_abs_deviation bmad_checker #(.BLOCK_LOG2(BLOCK_LOG2)) u_bmad_checker (.*);

FILE: verif/tb_block_mean_abs_deviation.sv
// Self-checking testbench for block_mean_abs_deviation: drives random sample streams,
// predicts each block's mean and absolute deviation sum, and compares every result.
// Depends on design/bmad_pkg.sv and design/block_mean_abs_deviation.sv.
`timescale 1ns / 1ps

module tb_block_mean_abs_deviation;

    import bmad_pkg::*;

    localparam int BLOCK_LOG2    = 5;
    localparam int SAMPLE_BITS   = 10;
    localparam int BLOCK_SIZE    = 1 << BLOCK_LOG2;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int MEAN_MAX      = (1 << MEAN_W) - 1;
    localparam int DEV_MAX       = (1 << DEV_W) - 1;
    localparam int TOTAL_SAMPLES = 1728;
    localparam int SETTLE_CYCLES = 2 * (BLOCK_SIZE + 3);
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int REPORT_LIMIT  = 10;

    // Sample patterns used to fill one block of the random part.
    typedef enum int {
        PAT_UNIFORM,
        PAT_CONSTANT,
        PAT_RAILS,
        PAT_NARROW,
        PAT_ALTERNATE
    } block_pattern_t;

    // Tracks the sample buffer and running sum, and queues the block results they imply.
    class block_dev_tracker_t;
        logic [SAMPLE_W-1:0]   samples [BLOCK_SIZE];
        bit   [BLOCK_LOG2-1:0] wr_pos = '0;
        longint unsigned       block_total = 0;
        logic [MEAN_W-1:0]     mean_q [$];
        logic [DEV_W-1:0]      dev_q [$];
        int unsigned           fail_count = 0;

        function void note_failure(string msg);
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        // Store one accepted sample; at block end, queue the mean and deviation sum.
        function void add_sample(logic [SAMPLE_W-1:0] s);
            longint unsigned mean;
            longint unsigned dev;
            logic [SAMPLE_W-1:0] used;
            used = s & SAMPLE_W'(SAMPLE_MAX);
            samples[wr_pos] = used;
            block_total += used;
            wr_pos++;
            if (wr_pos == 0)
            begin
                mean = block_total >> BLOCK_LOG2;
                dev = 0;
                foreach (samples[k])
                begin
                    if (samples[k] >= mean)
                        dev += samples[k] - mean;
                    else
                        dev += mean - samples[k];
                end
                mean_q.push_back(MEAN_W'((mean > MEAN_MAX) ? MEAN_MAX : mean));
                dev_q.push_back(DEV_W'((dev > DEV_MAX) ? DEV_MAX : dev));
                block_total = 0;
            end
        endfunction

        // Compare one result transfer with the oldest queued block result.
        function void check_result(logic [MEAN_W-1:0] mean, logic [DEV_W-1:0] dev);
            logic [MEAN_W-1:0] want_mean;
            logic [DEV_W-1:0]  want_dev;
            if (mean_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result: mean %0d dev %0d", mean, dev));
                return;
            end
            want_mean = mean_q.pop_front();
            want_dev  = dev_q.pop_front();
            if (mean !== want_mean)
                note_failure($sformatf("block_mean: expected %0d, got %0d", want_mean, mean));
            if (dev !== want_dev)
                note_failure($sformatf("abs_deviation_sum: expected %0d, got %0d",
                                       want_dev, dev));
        endfunction

        function int unsigned pending();
            return mean_q.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [MEAN_W-1:0]   block_mean;
    logic [DEV_W-1:0]    abs_deviation_sum;

    block_dev_tracker_t board;
    int unsigned        sent_count = 0;
    int unsigned        cycle_count = 0;
    int unsigned        sender_max_gap = 8;
    int unsigned        receiver_max_stall = 8;
    bit                 hold_request = 1'b0;

    logic [SAMPLE_W-1:0] corner_values [24] = '{
        10'd0, 10'd1023, 10'd0, 10'd1023, 10'd1, 10'd1022, 10'd512, 10'd511,
        10'h155, 10'h2AA, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd256, 10'd128,
        10'd64, 10'd32, 10'd16, 10'd8, 10'd4, 10'd2, 10'd1, 10'd1000
    };

    block_mean_abs_deviation #(
        .BLOCK_LOG2 (BLOCK_LOG2),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .block_mean       (block_mean),
        .abs_deviation_sum(abs_deviation_sum)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Watch both channels; every transfer feeds the tracker.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                board.add_sample(sample);
            if (out_valid && !out_stall)
                board.check_result(block_mean, abs_deviation_sum);
        end
    end

    // Result side: stall a random number of cycles before each transfer, or a long
    // stretch when asked, so the block backs up into its input.
    initial
    begin : result_sink
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
                hold = $urandom_range(0, receiver_max_stall);
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one sample after a random gap and hold it until the transfer.
    task automatic send_sample(logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = $urandom_range(0, sender_max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (in_stall);
        sent_count++;
    endtask

    // Stop offering samples until every queued result has come out, then let the
    // deviation pass of any partial work settle.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pattern_value(block_pattern_t pat,
                                                          int unsigned idx,
                                                          int unsigned base);
        case (pat)
            PAT_CONSTANT:  return SAMPLE_W'(base);
            PAT_RAILS:     return SAMPLE_W'($urandom_range(0, 1) ? SAMPLE_MAX : 0);
            PAT_NARROW:    return SAMPLE_W'(base + $urandom_range(0, 15));
            PAT_ALTERNATE: return SAMPLE_W'(idx[0] ? SAMPLE_MAX : 0);
            default:       return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    // Main sequence: reset, corner samples, then random blocks in several idling modes.
    initial
    begin : stimulus
        int unsigned    blk;
        int unsigned    base;
        block_pattern_t pat;
        board = new;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (corner_values[i])
            send_sample(corner_values[i]);

        blk  = 0;
        pat  = PAT_RAILS;
        base = 0;
        while (sent_count < TOTAL_SAMPLES || sent_count % BLOCK_SIZE != 0)
        begin
            if (sent_count % BLOCK_SIZE == 0)
            begin
                blk++;
                if (blk == 18)
                    wait_for_results();
                case (blk % 5)
                    0:
                    begin
                        sender_max_gap     = 0;
                        receiver_max_stall = 0;
                    end
                    1:
                    begin
                        sender_max_gap     = 0;
                        receiver_max_stall = 8;
                    end
                    2:
                    begin
                        sender_max_gap     = 8;
                        receiver_max_stall = 0;
                    end
                    default:
                    begin
                        sender_max_gap     = 8;
                        receiver_max_stall = 8;
                    end
                endcase
                // Back-to-back samples against a long result stall fill the block.
                if (blk == 30)
                    hold_request = 1'b1;
                if (blk >= 30 && blk < 34)
                    sender_max_gap = 0;
                pat  = block_pattern_t'($urandom_range(0, int'(PAT_ALTERNATE)));
                base = $urandom_range(0, SAMPLE_MAX - 15);
            end
            send_sample(pattern_value(pat, sent_count, base));
        end

        wait_for_results();
        if (board.fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: block_mean_abs_deviation.f
design/bmad_pkg.sv
design/bmad_mem.sv
design/bmad_scan.sv
design/block_mean_abs_deviation.sv
design/bmad_checker.sv
verif/tb_block_mean_abs_deviation.sv
